FILE: src/hbc_pkg.sv
// Shared types and constants for the HSV blob centroid unit.
// Used by the controller, the datapath, the divider and the top level.
package hbc_pkg;

    // Divider operand selects.
    localparam logic [1:0] SEL_SAT = 2'd0;
    localparam logic [1:0] SEL_HUE = 2'd1;
    localparam logic [1:0] SEL_X   = 2'd2;
    localparam logic [1:0] SEL_Y   = 2'd3;

    // Quotient sizes for the pixel and the centroid divisions.
    localparam int QW = 17;
    localparam logic [4:0] QB_PIX = 5'd8;
    localparam logic [4:0] QB_CTR = 5'd17;

    // Configuration register indexes.
    localparam logic [2:0] REG_HUE_LOW  = 3'd0;
    localparam logic [2:0] REG_HUE_HIGH = 3'd1;
    localparam logic [2:0] REG_SAT_LOW  = 3'd2;
    localparam logic [2:0] REG_SAT_HIGH = 3'd3;
    localparam logic [2:0] REG_VAL_LOW  = 3'd4;
    localparam logic [2:0] REG_VAL_HIGH = 3'd5;

    localparam logic [7:0] RST_HUE_LOW  = 8'd90;
    localparam logic [7:0] RST_HUE_HIGH = 8'd150;
    localparam logic [7:0] RST_SAT_LOW  = 8'd50;
    localparam logic [7:0] RST_SAT_HIGH = 8'd255;
    localparam logic [7:0] RST_VAL_LOW  = 8'd0;
    localparam logic [7:0] RST_VAL_HIGH = 8'd255;

    typedef struct packed {
        logic       load_pix;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_cap;
        logic       accum;
        logic       mul;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic last;
        logic hit_zero;
        logic out_full;
    } t_status;

endpackage

FILE: src/hbc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on hbc_pkg for the quotient width.
module hbc_div #(
    parameter int DIVW = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVW-1:0]       i_dividend,
    input  logic [DIVW-1:0]       i_divisor,   // already shifted up by nbits-1
    input  logic [4:0]            i_nbits,
    output logic                  o_done,
    output logic [hbc_pkg::QW-1:0] o_quot
);
    logic [DIVW-1:0]        r_rem;
    logic [DIVW-1:0]        r_ds;
    logic [hbc_pkg::QW-1:0] r_q;
    logic [4:0]             r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic                   ge;

    assign ge = (r_rem >= r_ds);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_ds  <= i_divisor;
            r_q   <= '0;
            r_cnt <= i_nbits;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_ds;
            end
            r_q   <= {r_q[hbc_pkg::QW-2:0], ge};
            r_ds  <= r_ds >> 1;
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: src/hbc_ctrl.sv
// Sequencing state machine for the HSV blob centroid unit.
// Depends on hbc_pkg for the command and status structs.
module hbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  hbc_pkg::t_status i_status,
    output hbc_pkg::t_cmd    o_cmd
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SS   = 4'd1;
    localparam logic [3:0] ST_WS   = 4'd2;
    localparam logic [3:0] ST_SH   = 4'd3;
    localparam logic [3:0] ST_WH   = 4'd4;
    localparam logic [3:0] ST_ACC  = 4'd5;
    localparam logic [3:0] ST_MUL  = 4'd6;
    localparam logic [3:0] ST_SX   = 4'd7;
    localparam logic [3:0] ST_WX   = 4'd8;
    localparam logic [3:0] ST_SY   = 4'd9;
    localparam logic [3:0] ST_WY   = 4'd10;
    localparam logic [3:0] ST_EMIT = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load_pix = i_in_valid;
                if (i_in_valid) n_state = ST_SS;
            end
            ST_SS: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = hbc_pkg::SEL_SAT;
                n_state         = ST_WS;
            end
            ST_WS: begin
                o_cmd.div_sel = hbc_pkg::SEL_SAT;
                o_cmd.div_cap = i_status.div_done;
                if (i_status.div_done) n_state = ST_SH;
            end
            ST_SH: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = hbc_pkg::SEL_HUE;
                n_state         = ST_WH;
            end
            ST_WH: begin
                o_cmd.div_sel = hbc_pkg::SEL_HUE;
                o_cmd.div_cap = i_status.div_done;
                if (i_status.div_done) n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.accum = 1'b1;
                n_state     = i_status.last ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_status.hit_zero ? ST_EMIT : ST_SX;
            end
            ST_SX: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = hbc_pkg::SEL_X;
                n_state         = ST_WX;
            end
            ST_WX: begin
                o_cmd.div_sel = hbc_pkg::SEL_X;
                o_cmd.div_cap = i_status.div_done;
                if (i_status.div_done) n_state = ST_SY;
            end
            ST_SY: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = hbc_pkg::SEL_Y;
                n_state         = ST_WY;
            end
            ST_WY: begin
                o_cmd.div_sel = hbc_pkg::SEL_Y;
                o_cmd.div_cap = i_status.div_done;
                if (i_status.div_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold the result until the output register is free.
                o_cmd.emit = !i_status.out_full;
                if (!i_status.out_full) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

FILE: src/hbc_datapath.sv
// Datapath: HSV front end, shared divider, frame accumulators and result register.
// Depends on hbc_pkg and hbc_div.
module hbc_datapath #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hbc_pkg::t_cmd    i_cmd,
    output hbc_pkg::t_status o_status,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    input  logic             i_frame_end,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_onscreen,
    output logic [15:0]      o_err_x,
    output logic [15:0]      o_err_y
);
    localparam int CW   = $clog2(FRAME_WIDTH);
    localparam int RW   = $clog2(FRAME_HEIGHT + 1);
    localparam int HW   = $clog2(FRAME_WIDTH * FRAME_HEIGHT + 1);
    localparam int SUMW = HW + ((CW > RW) ? CW : RW);
    localparam int DXW  = HW + $clog2(FRAME_WIDTH + 1);
    localparam int DYW  = HW + $clog2(FRAME_HEIGHT + 1);
    localparam int DIVW = SUMW + 19;

    logic [7:0] r_hue_lo, r_hue_hi, r_sat_lo, r_sat_hi, r_val_lo, r_val_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_lo <= hbc_pkg::RST_HUE_LOW;
            r_hue_hi <= hbc_pkg::RST_HUE_HIGH;
            r_sat_lo <= hbc_pkg::RST_SAT_LOW;
            r_sat_hi <= hbc_pkg::RST_SAT_HIGH;
            r_val_lo <= hbc_pkg::RST_VAL_LOW;
            r_val_hi <= hbc_pkg::RST_VAL_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hbc_pkg::REG_HUE_LOW:  r_hue_lo <= i_cfg_data;
                hbc_pkg::REG_HUE_HIGH: r_hue_hi <= i_cfg_data;
                hbc_pkg::REG_SAT_LOW:  r_sat_lo <= i_cfg_data;
                hbc_pkg::REG_SAT_HIGH: r_sat_hi <= i_cfg_data;
                hbc_pkg::REG_VAL_LOW:  r_val_lo <= i_cfg_data;
                hbc_pkg::REG_VAL_HIGH: r_val_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // HSV front end: max, spread and the sixths-scaled hue angle.
    logic [7:0]  mx, mn, dd;
    logic [10:0] h6;

    always_comb begin
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        dd = mx - mn;
        if (mx == i_red) begin
            if (i_green >= i_blue) h6 = 11'(i_green - i_blue);
            else h6 = 11'(11'd6 * 11'(dd) - 11'(i_blue - i_green));
        end else if (mx == i_green) begin
            h6 = 11'(11'(i_blue) + 11'(2 * dd) - 11'(i_red));
        end else begin
            h6 = 11'(11'(i_red) + 11'd4 * 11'(dd) - 11'(i_green));
        end
    end

    logic [7:0]  r_v, r_d, r_s, r_h;
    logic [10:0] r_h6;
    logic        r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_v    <= mx;
            r_d    <= dd;
            r_h6   <= h6;
            r_last <= i_frame_end;
        end
    end

    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [HW-1:0]   r_hit;
    logic [SUMW-1:0] r_sumc, r_sumr;
    logic [DXW-1:0]  r_dx;
    logic [DYW-1:0]  r_dy;
    logic [hbc_pkg::QW-1:0] r_qx, r_qy;

    // Divider operand selection.
    logic [DIVW-1:0] div_num, div_den;
    logic [4:0]      div_nb;
    logic [16:0]     s_num, h_num;
    logic            div_done;
    logic [hbc_pkg::QW-1:0] div_q;

    assign s_num = 17'(r_d) * 17'd510 + 17'(r_v);
    assign h_num = 17'(r_h6) * 17'd60 + 17'(r_d);

    always_comb begin
        case (i_cmd.div_sel)
            hbc_pkg::SEL_SAT: begin
                div_num = DIVW'(s_num);
                div_den = DIVW'({r_v, 1'b0}) << 7;
                div_nb  = hbc_pkg::QB_PIX;
            end
            hbc_pkg::SEL_HUE: begin
                div_num = DIVW'(h_num);
                div_den = DIVW'({r_d, 1'b0}) << 7;
                div_nb  = hbc_pkg::QB_PIX;
            end
            hbc_pkg::SEL_X: begin
                div_num = (DIVW'(r_sumc) << 17) + DIVW'(r_dx);
                div_den = DIVW'(r_dx) << 17;
                div_nb  = hbc_pkg::QB_CTR;
            end
            default: begin
                div_num = (DIVW'(r_sumr) << 17) + DIVW'(r_dy);
                div_den = DIVW'(r_dy) << 17;
                div_nb  = hbc_pkg::QB_CTR;
            end
        endcase
    end

    hbc_div #(.DIVW(DIVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .i_nbits    (div_nb),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_cap) begin
            case (i_cmd.div_sel)
                hbc_pkg::SEL_SAT: r_s <= (r_v == 8'd0) ? 8'd0 : div_q[7:0];
                hbc_pkg::SEL_HUE: r_h <= (r_d == 8'd0 || div_q[7:0] >= 8'd180) ?
                                         8'd0 : div_q[7:0];
                hbc_pkg::SEL_X:   r_qx <= div_q;
                default:          r_qy <= div_q;
            endcase
        end
        if (i_cmd.mul) begin
            r_dx <= DXW'(r_hit) * DXW'(FRAME_WIDTH);
            r_dy <= DYW'(r_hit) * DYW'(FRAME_HEIGHT);
        end
    end

    logic kept;
    assign kept = (r_h >= r_hue_lo) && (r_h <= r_hue_hi) &&
                  (r_s >= r_sat_lo) && (r_s <= r_sat_hi) &&
                  (r_v >= r_val_lo) && (r_v <= r_val_hi);

    // Centroid offsets with saturation to the signed 16-bit range.
    logic signed [17:0] ex, ey;
    logic [15:0] ex_sat, ey_sat;
    assign ex = $signed({1'b0, r_qx}) - 18'sd32768;
    assign ey = 18'sd32768 - $signed({1'b0, r_qy});
    assign ex_sat = (ex > 18'sd32767) ? 16'h7FFF : ex[15:0];
    assign ey_sat = (ey > 18'sd32767) ? 16'h7FFF : ey[15:0];

    logic [15:0] r_last_ex, r_last_ey;
    logic        r_ovalid, r_on;
    logic [15:0] r_oex, r_oey;
    logic        hit_zero;
    assign hit_zero = (r_hit == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_hit     <= '0;
            r_sumc    <= '0;
            r_sumr    <= '0;
            r_last_ex <= '0;
            r_last_ey <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.accum && r_row < RW'(FRAME_HEIGHT)) begin
                if (kept) begin
                    r_hit  <= r_hit + HW'(1);
                    r_sumc <= r_sumc + SUMW'(r_col);
                    r_sumr <= r_sumr + SUMW'(r_row);
                end
                if (r_col == CW'(FRAME_WIDTH - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
                r_on     <= !hit_zero;
                if (!hit_zero) begin
                    r_last_ex <= ex_sat;
                    r_last_ey <= ey_sat;
                    r_oex     <= ex_sat;
                    r_oey     <= ey_sat;
                end else begin
                    r_oex <= r_last_ex;
                    r_oey <= r_last_ey;
                end
                r_col  <= '0;
                r_row  <= '0;
                r_hit  <= '0;
                r_sumc <= '0;
                r_sumr <= '0;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.last     = r_last;
    assign o_status.hit_zero = hit_zero;
    assign o_status.out_full = r_ovalid;

    assign o_out_valid = r_ovalid;
    assign o_onscreen  = r_on;
    assign o_err_x     = r_oex;
    assign o_err_y     = r_oey;
endmodule

FILE: src/hsv_blob_centroid_unit.sv
// HSV color-threshold blob centroid unit, top level.
// Depends on hbc_pkg, hbc_ctrl and hbc_datapath.
//
// Pixels arrive in raster order as beats on the s_axis channel; tlast marks
// the last pixel of a frame. Each pixel is turned into HSV, tested against
// the six threshold registers, and kept pixels are counted and their column
// and row summed. On the tlast beat one result beat leaves on m_axis:
// tuser is the onscreen flag, tdata carries the Q1.15 offsets err_x and err_y.
// A frame without kept pixels repeats the last offsets with onscreen low.
// One pixel is in work at a time. Saturation and hue each take one pass of
// the shared bit-serial divider, so tready stays low after each accepted
// pixel at least until both passes are done and the pixel is accumulated. A
// tlast beat adds a multiply step and, when any pixel was kept, two 17-bit
// divisions before the result beat is shown. The result sits in an output
// register: when the receiver stalls, further pixels are still taken and
// only a second frame result waits for it, which holds off the input until
// the first result beat is taken. Synchronous reset returns the thresholds
// to their defaults and clears the position, the sums and the last offsets.
// Threshold registers are written through i_cfg_*; the user must do so only
// while the unit is idle, which the block itself does not enforce.
module hsv_blob_centroid_unit #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // err_x [15:0], err_y [31:16]
    output logic        m_axis_tuser,   // onscreen
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    hbc_pkg::t_cmd    cmd;
    hbc_pkg::t_status status;
    logic [15:0]      err_x, err_y;

    hbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hbc_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_red       (s_axis_tdata[7:0]),
        .i_green     (s_axis_tdata[15:8]),
        .i_blue      (s_axis_tdata[23:16]),
        .i_frame_end (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_onscreen  (m_axis_tuser),
        .o_err_x     (err_x),
        .o_err_y     (err_y)
    );

    assign m_axis_tdata = {err_y, err_x};
endmodule

FILE: src/hbc_checker.sv
// Port-level checks for the HSV blob centroid unit, bound to the top level.
// Depends only on the top-level ports.
module hbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat present right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    a_one_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second pixel taken while one is in work");

    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("result beat repeated");
endmodule

bind hsv_blob_centroid_unit hbc_checker u_hbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
